FILE: sv/dmc_pkg.sv
// ----------------------------------------------------------------------------
// dmc_pkg: shared types and constants for the direct-mapped read cache
// Geometry, field widths, register map codes and the sequencer state type.
// ----------------------------------------------------------------------------
package dmc_pkg;

    localparam int NUM_LINES  = 4;
    localparam int LINE_BYTES = 8;
    localparam int MEM_BYTES  = 1024;

    localparam int DATA_W  = 8;
    localparam int BYTE_W  = $clog2(LINE_BYTES);
    localparam int LINE_W  = $clog2(NUM_LINES);
    localparam int MEM_W   = $clog2(MEM_BYTES);
    localparam int BLOCK_W = MEM_W - BYTE_W;
    localparam int TAG_W   = BLOCK_W - LINE_W;

    localparam int FILL_CNT_W = $clog2(LINE_BYTES + 1);

    localparam int CNT_W   = 32;
    localparam int PEN_W   = 8;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [PEN_W-1:0] PENALTY_RESET = PEN_W'(10);

    // register index, taken from paddr[2]
    localparam logic REG_MISS_PENALTY = 1'b0;

    // item opcodes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_ACCESS = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_FILL,
        ST_FINISH
    } seq_state_t;

    // sequencer to line store
    typedef struct packed {
        logic              wr_en;
        logic [BYTE_W-1:0] byte_sel;
        logic              commit;
    } fill_ctl_t;

    // sequencer to top level
    typedef struct packed {
        logic              idle;
        logic              load_out;
        logic              missed;
        logic [BYTE_W-1:0] rd_offset;
    } seq_ctl_t;

endpackage

FILE: sv/dmc_backing_mem.sv
// ----------------------------------------------------------------------------
// dmc_backing_mem: byte-wide backing memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dmc_backing_mem (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [dmc_pkg::MEM_W-1:0]  waddr,
    input  logic [dmc_pkg::DATA_W-1:0] wdata,
    input  logic [dmc_pkg::MEM_W-1:0]  raddr,
    output logic [dmc_pkg::DATA_W-1:0] rdata
);

    logic [dmc_pkg::DATA_W-1:0] mem [dmc_pkg::MEM_BYTES];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/dmc_line_store.sv
// ----------------------------------------------------------------------------
// dmc_line_store: cache lines, tags and valid bits
// Tag compare and byte select for the current item; byte-at-a-time refill.
// ----------------------------------------------------------------------------
module dmc_line_store (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [dmc_pkg::LINE_W-1:0] line_idx,
    input  logic [dmc_pkg::TAG_W-1:0]  tag,
    input  logic [dmc_pkg::BYTE_W-1:0] word,
    input  dmc_pkg::fill_ctl_t         fill,
    input  logic [dmc_pkg::DATA_W-1:0] fill_data,
    output logic                       hit,
    output logic [dmc_pkg::DATA_W-1:0] rd_byte
);

    logic                       line_valid_reg [dmc_pkg::NUM_LINES];
    logic [dmc_pkg::TAG_W-1:0]  line_tag_reg   [dmc_pkg::NUM_LINES];
    logic [dmc_pkg::DATA_W-1:0] line_data_reg  [dmc_pkg::NUM_LINES][dmc_pkg::LINE_BYTES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < dmc_pkg::NUM_LINES; i++) begin
                line_valid_reg[i] <= 1'b0;
                for (int j = 0; j < dmc_pkg::LINE_BYTES; j++) begin
                    line_data_reg[i][j] <= '0;
                end
            end
        end else begin
            if (fill.wr_en) begin
                line_data_reg[line_idx][fill.byte_sel] <= fill_data;
            end
            if (fill.commit) begin
                line_valid_reg[line_idx] <= 1'b1;
            end
        end
    end

    // tags are only looked at while valid
    always_ff @(posedge aclk) begin
        if (fill.commit) begin
            line_tag_reg[line_idx] <= tag;
        end
    end

    assign hit     = line_valid_reg[line_idx] && (line_tag_reg[line_idx] == tag);
    assign rd_byte = line_data_reg[line_idx][word];

endmodule

FILE: sv/dmc_seq.sv
// ----------------------------------------------------------------------------
// dmc_seq: lookup and refill sequencer
// Steps the backing-memory read port through one block on a miss.
// ----------------------------------------------------------------------------
module dmc_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic                hit,
    input  logic                out_free,
    output dmc_pkg::fill_ctl_t  fill,
    output dmc_pkg::seq_ctl_t   ctl
);

    localparam int CW = dmc_pkg::FILL_CNT_W;
    localparam int BW = dmc_pkg::BYTE_W;

    dmc_pkg::seq_state_t state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       cnt_prev;

    assign cnt_prev = cnt_reg - CW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dmc_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        fill.wr_en    = 1'b0;
        fill.byte_sel = cnt_prev[BW-1:0];
        fill.commit   = 1'b0;
        ctl.idle      = 1'b0;
        ctl.load_out  = 1'b0;
        ctl.missed    = 1'b0;
        ctl.rd_offset = cnt_reg[BW-1:0];
        unique case (state_reg)
            dmc_pkg::ST_IDLE: begin
                ctl.idle = 1'b1;
                if (start) begin
                    state_next = dmc_pkg::ST_LOOKUP;
                end
            end
            dmc_pkg::ST_LOOKUP: begin
                if (!hit) begin
                    cnt_next   = '0;
                    state_next = dmc_pkg::ST_FILL;
                end else if (out_free) begin
                    ctl.load_out = 1'b1;
                    state_next   = dmc_pkg::ST_IDLE;
                end
            end
            dmc_pkg::ST_FILL: begin
                // the backing memory registers its read data, so each byte lags its address
                fill.wr_en = (cnt_reg != '0);
                cnt_next   = cnt_reg + CW'(1);
                if (cnt_reg == CW'(dmc_pkg::LINE_BYTES)) begin
                    fill.commit = 1'b1;
                    state_next  = dmc_pkg::ST_FINISH;
                end
            end
            dmc_pkg::ST_FINISH: begin
                ctl.missed = 1'b1;
                if (out_free) begin
                    ctl.load_out = 1'b1;
                    state_next   = dmc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dmc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/direct_mapped_cache_read.sv
// ----------------------------------------------------------------------------
// direct_mapped_cache_read: read-only direct-mapped cache, 4 lines x 8 bytes
// Load items fill the 1024-byte backing memory; access items go through the
// cache and return the byte, its address fields, simulated time and counts.
//
//   channel  direction  handshake               payload
//   s_       in         s_valid / s_ready       op, address, write_byte
//   m_       out        m_valid / m_ready       hit, data, fields, time, totals
//   apb      in         psel/penable/pready     miss_penalty at 0x0
//
// A load transaction needs only the accept step. A hit passes through accept
// and lookup; a miss adds a refill that reads the backing memory one byte per cycle
// through its single read port, whose read data is registered, and a finish step.
// Reset clears valid bits, line data, time and counters; miss_penalty is 10.
// A result waits in the output register; a finished access stalls only
// while that register is still full.
// ----------------------------------------------------------------------------
module direct_mapped_cache_read (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dmc_pkg::PADDR_W-1:0] paddr,
    input  logic [dmc_pkg::PDATA_W-1:0] pwdata,
    output logic [dmc_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_op,
    input  logic [9:0]                  s_address,
    input  logic [7:0]                  s_write_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_first_try_hit,
    output logic [7:0]                  m_read_data,
    output logic [4:0]                  m_tag_field,
    output logic [1:0]                  m_line_index,
    output logic [2:0]                  m_word_offset,
    output logic [6:0]                  m_block_number,
    output logic [31:0]                 m_access_time,
    output logic [31:0]                 m_access_total,
    output logic [31:0]                 m_miss_total
);

    localparam int CW = dmc_pkg::CNT_W;

    logic [dmc_pkg::PEN_W-1:0]  penalty_reg;
    logic                       cfg_wr;

    logic [dmc_pkg::TAG_W-1:0]  tag_reg;
    logic [dmc_pkg::LINE_W-1:0] line_reg;
    logic [dmc_pkg::BYTE_W-1:0] word_reg;

    logic [CW-1:0] sim_time_reg, access_cnt_reg, miss_cnt_reg;
    logic [CW-1:0] time_val;

    logic                       m_valid_reg;
    logic                       out_free;
    logic                       s_accept;

    logic                       hit;
    logic [dmc_pkg::DATA_W-1:0] rd_byte;
    logic [dmc_pkg::DATA_W-1:0] mem_rdata;
    logic [dmc_pkg::MEM_W-1:0]  mem_raddr;

    dmc_pkg::fill_ctl_t fill;
    dmc_pkg::seq_ctl_t  ctl;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == dmc_pkg::REG_MISS_PENALTY);
    assign prdata = (paddr[2] == dmc_pkg::REG_MISS_PENALTY)
                  ? dmc_pkg::PDATA_W'(penalty_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            penalty_reg <= dmc_pkg::PENALTY_RESET;
        end else if (cfg_wr) begin
            penalty_reg <= pwdata[dmc_pkg::PEN_W-1:0];
        end
    end

    // input side
    assign s_ready  = ctl.idle;
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (s_accept && (s_op == dmc_pkg::OP_ACCESS)) begin
            word_reg <= s_address[dmc_pkg::BYTE_W-1:0];
            line_reg <= s_address[dmc_pkg::BYTE_W +: dmc_pkg::LINE_W];
            tag_reg  <= s_address[dmc_pkg::BYTE_W + dmc_pkg::LINE_W +: dmc_pkg::TAG_W];
        end
    end

    assign mem_raddr = {tag_reg, line_reg, ctl.rd_offset};

    dmc_backing_mem u_mem (
        .aclk  (aclk),
        .we    (s_accept && (s_op == dmc_pkg::OP_LOAD)),
        .waddr (s_address),
        .wdata (s_write_byte),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    dmc_line_store u_lines (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .line_idx  (line_reg),
        .tag       (tag_reg),
        .word      (word_reg),
        .fill      (fill),
        .fill_data (mem_rdata),
        .hit       (hit),
        .rd_byte   (rd_byte)
    );

    dmc_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_accept && (s_op == dmc_pkg::OP_ACCESS)),
        .hit      (hit),
        .out_free (out_free),
        .fill     (fill),
        .ctl      (ctl)
    );

    // time and counters
    assign time_val = ctl.missed ? (sim_time_reg + CW'(penalty_reg)) : sim_time_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sim_time_reg   <= '0;
            access_cnt_reg <= '0;
            miss_cnt_reg   <= '0;
        end else if (ctl.load_out) begin
            sim_time_reg   <= time_val + CW'(1);
            // a miss counts as two accesses
            access_cnt_reg <= access_cnt_reg + (ctl.missed ? CW'(2) : CW'(1));
            miss_cnt_reg   <= miss_cnt_reg + CW'(ctl.missed);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_out) begin
            m_first_try_hit <= !ctl.missed;
            m_read_data     <= rd_byte;
            m_tag_field     <= tag_reg;
            m_line_index    <= line_reg;
            m_word_offset   <= word_reg;
            m_block_number  <= {tag_reg, line_reg};
            m_access_time   <= time_val;
            m_access_total  <= access_cnt_reg + (ctl.missed ? CW'(2) : CW'(1));
            m_miss_total    <= miss_cnt_reg + CW'(ctl.missed);
        end
    end

    assign m_valid = m_valid_reg;

    // checks
    a_busy_after_access: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_op == dmc_pkg::OP_ACCESS) |=> !s_ready)
        else $error("input accepted during lookup");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_op == dmc_pkg::OP_LOAD && !m_valid) |=> !m_valid)
        else $error("load transaction produced a result");

    a_hit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.load_out && !ctl.missed) |=> (access_cnt_reg == $past(access_cnt_reg) + CW'(1))
            && (miss_cnt_reg == $past(miss_cnt_reg)))
        else $error("hit miscounted");

    a_miss_filled: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.load_out && ctl.missed) |-> hit)
        else $error("refilled line does not hit");

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for direct_mapped_cache_read
// A mirror of the cache state predicts every access result at the handshake
// and checks each result field by field. Stimulus fills whole blocks before
// they are read. It mixes loads, accesses and stray loads under changing miss
// penalties and idle patterns, and includes a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 16;

    typedef struct packed {
        logic                        first_try_hit;
        logic [dmc_pkg::DATA_W-1:0]  read_data;
        logic [dmc_pkg::TAG_W-1:0]   tag_field;
        logic [dmc_pkg::LINE_W-1:0]  line_index;
        logic [dmc_pkg::BYTE_W-1:0]  word_offset;
        logic [dmc_pkg::BLOCK_W-1:0] block_number;
        logic [dmc_pkg::CNT_W-1:0]   access_time;
        logic [dmc_pkg::CNT_W-1:0]   access_total;
        logic [dmc_pkg::CNT_W-1:0]   miss_total;
    } cache_reply_t;

    class read_cache_mirror;
        bit                         line_live[dmc_pkg::NUM_LINES];
        logic [dmc_pkg::TAG_W-1:0]  line_tag[dmc_pkg::NUM_LINES];
        logic [dmc_pkg::DATA_W-1:0] line_data[dmc_pkg::NUM_LINES][dmc_pkg::LINE_BYTES];
        logic [dmc_pkg::DATA_W-1:0] mem[dmc_pkg::MEM_BYTES];
        logic [dmc_pkg::CNT_W-1:0]  now;
        logic [dmc_pkg::CNT_W-1:0]  accesses;
        logic [dmc_pkg::CNT_W-1:0]  misses;
        logic [dmc_pkg::PEN_W-1:0]  penalty;
        cache_reply_t               pending_reads[$];
        int                         mismatches;

        function new();
            foreach (line_live[i]) line_live[i] = 1'b0;
            foreach (line_data[i, j]) line_data[i][j] = '0;
            foreach (mem[i]) mem[i] = '0;
            now        = '0;
            accesses   = '0;
            misses     = '0;
            penalty    = dmc_pkg::PENALTY_RESET;
            mismatches = 0;
        endfunction

        function void apply_item(logic op, logic [dmc_pkg::MEM_W-1:0] addr,
                                 logic [dmc_pkg::DATA_W-1:0] wbyte);
            logic [dmc_pkg::BLOCK_W-1:0] blk;
            logic [dmc_pkg::LINE_W-1:0]  ln;
            logic [dmc_pkg::TAG_W-1:0]   tg;
            logic [dmc_pkg::BYTE_W-1:0]  wd;
            logic [dmc_pkg::CNT_W-1:0]   t;
            cache_reply_t                r;
            bit                          hit;
            int                          i;
            if (op == dmc_pkg::OP_LOAD) begin
                mem[addr] = wbyte;
                return;
            end
            wd  = addr[dmc_pkg::BYTE_W-1:0];
            blk = addr[dmc_pkg::MEM_W-1:dmc_pkg::BYTE_W];
            ln  = blk[dmc_pkg::LINE_W-1:0];
            tg  = blk[dmc_pkg::BLOCK_W-1:dmc_pkg::LINE_W];
            hit = line_live[ln] && (line_tag[ln] == tg);
            t   = now;
            if (!hit) begin
                for (i = 0; i < dmc_pkg::LINE_BYTES; i++)
                    line_data[ln][i] = mem[{blk, dmc_pkg::BYTE_W'(i)}];
                line_live[ln] = 1'b1;
                line_tag[ln]  = tg;
                misses   += 1;
                accesses += 1;
                t        += penalty;
            end
            accesses += 1;
            now = t + 1;
            r.first_try_hit = hit;
            r.read_data     = line_data[ln][wd];
            r.tag_field     = tg;
            r.line_index    = ln;
            r.word_offset   = wd;
            r.block_number  = blk;
            r.access_time   = t;
            r.access_total  = accesses;
            r.miss_total    = misses;
            pending_reads.push_back(r);
        endfunction

        function void check_field(string field, logic [dmc_pkg::CNT_W-1:0] want,
                                  logic [dmc_pkg::CNT_W-1:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void match_reply(cache_reply_t got);
            cache_reply_t want;
            if (pending_reads.size() == 0) begin
                $error("result transaction with no access outstanding");
                mismatches++;
                return;
            end
            want = pending_reads.pop_front();
            check_field("first_try_hit", dmc_pkg::CNT_W'(want.first_try_hit),
                        dmc_pkg::CNT_W'(got.first_try_hit));
            check_field("read_data", dmc_pkg::CNT_W'(want.read_data),
                        dmc_pkg::CNT_W'(got.read_data));
            check_field("tag_field", dmc_pkg::CNT_W'(want.tag_field),
                        dmc_pkg::CNT_W'(got.tag_field));
            check_field("line_index", dmc_pkg::CNT_W'(want.line_index),
                        dmc_pkg::CNT_W'(got.line_index));
            check_field("word_offset", dmc_pkg::CNT_W'(want.word_offset),
                        dmc_pkg::CNT_W'(got.word_offset));
            check_field("block_number", dmc_pkg::CNT_W'(want.block_number),
                        dmc_pkg::CNT_W'(got.block_number));
            check_field("access_time", want.access_time, got.access_time);
            check_field("access_total", want.access_total, got.access_total);
            check_field("miss_total", want.miss_total, got.miss_total);
        endfunction
    endclass

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [dmc_pkg::PADDR_W-1:0] paddr = '0;
    logic [dmc_pkg::PDATA_W-1:0] pwdata = '0;
    logic [dmc_pkg::PDATA_W-1:0] prdata;
    logic                        pready;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic                        s_op = dmc_pkg::OP_LOAD;
    logic [9:0]                  s_address = '0;
    logic [7:0]                  s_write_byte = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic                        m_first_try_hit;
    logic [7:0]                  m_read_data;
    logic [4:0]                  m_tag_field;
    logic [1:0]                  m_line_index;
    logic [2:0]                  m_word_offset;
    logic [6:0]                  m_block_number;
    logic [31:0]                 m_access_time;
    logic [31:0]                 m_access_total;
    logic [31:0]                 m_miss_total;

    read_cache_mirror            mirror = new();
    cache_reply_t                seen;
    bit                          loaded[dmc_pkg::MEM_BYTES];
    bit                          block_listed[1 << dmc_pkg::BLOCK_W];
    logic [dmc_pkg::BLOCK_W-1:0] ready_blocks[$];
    logic [dmc_pkg::BLOCK_W-1:0] recent_block = '0;
    bit                          hold_off = 1'b0;
    int                          idle_pct = 0;
    int                          stall_pct = 0;
    int                          quiet_cycles = 0;

    direct_mapped_cache_read u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_address       (s_address),
        .s_write_byte    (s_write_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_first_try_hit (m_first_try_hit),
        .m_read_data     (m_read_data),
        .m_tag_field     (m_tag_field),
        .m_line_index    (m_line_index),
        .m_word_offset   (m_word_offset),
        .m_block_number  (m_block_number),
        .m_access_time   (m_access_time),
        .m_access_total  (m_access_total),
        .m_miss_total    (m_miss_total)
    );

    always #6 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen.first_try_hit = m_first_try_hit;
            seen.read_data     = m_read_data;
            seen.tag_field     = m_tag_field;
            seen.line_index    = m_line_index;
            seen.word_offset   = m_word_offset;
            seen.block_number  = m_block_number;
            seen.access_time   = m_access_time;
            seen.access_total  = m_access_total;
            seen.miss_total    = m_miss_total;
            mirror.match_reply(seen);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("direct_mapped_cache_read test failed");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [dmc_pkg::MEM_W-1:0] addr,
                             input logic [dmc_pkg::DATA_W-1:0] wbyte);
        logic [dmc_pkg::BLOCK_W-1:0] blk;
        bit                          full;
        int                          i;
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= op;
        s_address    <= addr;
        s_write_byte <= wbyte;
        do @(posedge aclk); while (!s_ready);
        mirror.apply_item(op, addr, wbyte);
        if (op == dmc_pkg::OP_LOAD) begin
            loaded[addr] = 1'b1;
            blk = addr[dmc_pkg::MEM_W-1:dmc_pkg::BYTE_W];
            if (!block_listed[blk]) begin
                full = 1'b1;
                for (i = 0; i < dmc_pkg::LINE_BYTES; i++)
                    full &= loaded[{blk, dmc_pkg::BYTE_W'(i)}];
                // only blocks loaded in full may ever be read
                if (full) begin
                    block_listed[blk] = 1'b1;
                    ready_blocks.push_back(blk);
                end
            end
        end
    endtask

    task automatic write_penalty(input logic [dmc_pkg::PEN_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {dmc_pkg::REG_MISS_PENALTY, 2'b00};
        pwdata  <= {(dmc_pkg::PDATA_W - dmc_pkg::PEN_W)'($urandom), value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        mirror.penalty = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (mirror.pending_reads.size() != 0) @(posedge aclk);
        // let a trailing load finish before touching the register
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic random_traffic(input int count);
        logic [dmc_pkg::BLOCK_W-1:0] blk;
        int                          done;
        int                          roll;
        int                          i;
        done = 0;
        while (done < count) begin
            roll = $urandom_range(99);
            if (roll < 12) begin
                send_item(dmc_pkg::OP_LOAD, dmc_pkg::MEM_W'($urandom),
                          dmc_pkg::DATA_W'($urandom));
                done++;
            end else if (roll < 17) begin
                blk = dmc_pkg::BLOCK_W'($urandom);
                for (i = 0; i < dmc_pkg::LINE_BYTES; i++)
                    send_item(dmc_pkg::OP_LOAD, {blk, dmc_pkg::BYTE_W'(i)},
                              dmc_pkg::DATA_W'($urandom));
                done += dmc_pkg::LINE_BYTES;
            end else begin
                // stay on the last block half the time to get hits
                if ($urandom_range(1))
                    recent_block = ready_blocks[$urandom_range(ready_blocks.size() - 1)];
                send_item(dmc_pkg::OP_ACCESS, {recent_block, dmc_pkg::BYTE_W'($urandom)},
                          dmc_pkg::DATA_W'($urandom));
                done++;
            end
        end
    endtask

    task automatic run_phase(input int sender_idle, input int receiver_stall,
                             input logic [dmc_pkg::PEN_W-1:0] pen, input int count,
                             input bit squeeze);
        drain();
        write_penalty(pen);
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        if (squeeze) begin
            fork
                begin
                    hold_off = 1'b1;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                    hold_off = 1'b0;
                end
            join_none
        end
        random_traffic(count);
    endtask

    task automatic directed_items();
        int i;
        for (i = 0; i < dmc_pkg::LINE_BYTES; i++)
            send_item(dmc_pkg::OP_LOAD, {dmc_pkg::BLOCK_W'(0), dmc_pkg::BYTE_W'(i)},
                      (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : dmc_pkg::DATA_W'($urandom));
        for (i = 0; i < dmc_pkg::LINE_BYTES; i++)
            send_item(dmc_pkg::OP_LOAD, {dmc_pkg::BLOCK_W'('1), dmc_pkg::BYTE_W'(i)},
                      (i == 7) ? 8'hFF : (i == 0) ? 8'h00 : dmc_pkg::DATA_W'($urandom));
        // cold miss, then hit in the same line
        send_item(dmc_pkg::OP_ACCESS, dmc_pkg::MEM_W'(0), 8'hFF);
        send_item(dmc_pkg::OP_ACCESS, dmc_pkg::MEM_W'(1), 8'h00);
        send_item(dmc_pkg::OP_ACCESS, dmc_pkg::MEM_W'('1), 8'hFF);
        send_item(dmc_pkg::OP_ACCESS, {dmc_pkg::BLOCK_W'('1), dmc_pkg::BYTE_W'(0)}, 8'h00);
        // change memory under a cached line: the line keeps the old byte
        send_item(dmc_pkg::OP_LOAD, dmc_pkg::MEM_W'('1), 8'h5A);
        send_item(dmc_pkg::OP_ACCESS, dmc_pkg::MEM_W'('1), 8'h00);
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        directed_items();
        run_phase(0, 0, 8'd0, 300, 1'b0);
        run_phase(50, 0, 8'd255, 300, 1'b0);
        run_phase(0, 50, dmc_pkg::PEN_W'($urandom), 300, 1'b0);
        run_phase(7, 7, 8'd1, 300, 1'b0);
        run_phase(0, 0, dmc_pkg::PEN_W'($urandom), 300, 1'b1);
        drain();
        if (mirror.mismatches == 0 && mirror.pending_reads.size() == 0) begin
            $display("direct_mapped_cache_read test passed");
        end else begin
            $display("direct_mapped_cache_read test failed");
        end
        $finish;
    end

endmodule
